/* hw/rtl/idle_utilization_meter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the idle utilization meter
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IDLE_UTILIZATION_METER_ASSERT_SVH
`define IDLE_UTILIZATION_METER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define IUM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");
// Implication checked in the same cycle
`define IUM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`else
`define IUM_ASSERT(label, clk, rst_n, prop)
`define IUM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/ium_pkg.sv */
// ----------------------------------------------------------------------------
// ium_pkg
// Shared types, codes and constants of the idle utilization meter.
// ----------------------------------------------------------------------------
package ium_pkg;

  localparam int unsigned RING_DEPTH_DEF   = 16;
  localparam int unsigned REPORT_SLOTS_DEF = 4;
  localparam logic [31:0] EMPTY_MARK       = 32'hFFFF_FFFF;
  localparam int unsigned CFG_IDX_W        = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_FIRST  = 3'd0,
    REG_MULT_SECOND = 3'd1,
    REG_DIVISOR     = 3'd2,
    REG_DIAG_MASK   = 3'd3,
    REG_MARKS       = 3'd4,
    REG_FULL_SCALE  = 3'd5
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_IDLE_TICK = 2'd0,
    KIND_SYNC_MARK = 2'd1,
    KIND_QUERY     = 2'd2,
    KIND_REPORT    = 2'd3
  } in_kind_e;

  // Result kinds
  typedef enum logic {
    RES_UTIL   = 1'b0,
    RES_REPORT = 1'b1
  } res_kind_e;

  // Shared arithmetic unit operations
  typedef enum logic {
    AR_MUL = 1'b0,
    AR_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q_MUL1,
    ST_Q_WAIT1,
    ST_Q_DIV,
    ST_Q_WAITD,
    ST_Q_MUL2,
    ST_Q_WAIT2,
    ST_Q_OUT,
    ST_R_PREV,
    ST_R_PREV2,
    ST_R_RD,
    ST_R_DELTA,
    ST_B_RD,
    ST_B_CMP,
    ST_K_RD,
    ST_K_INS
  } seq_state_e;

endpackage

/* hw/rtl/ium_arith.sv */
// ----------------------------------------------------------------------------
// ium_arith
// Shared arithmetic unit: 32x32 multiply (low word) into a result register and a
// restoring 32-step divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ium_arith import ium_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arith_req_t  req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic        done_q;
  logic [31:0] res_q;

  logic [63:0] prod;
  logic [32:0] rem_sh;
  logic        fits;
  logic [32:0] rem_nx;
  logic [31:0] quo_nx;

  // Multiply and one divider step
  always_comb begin
    prod   = a_i * b_i;
    rem_sh = {rem_q[31:0], quo_q[31]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    quo_nx = {quo_q[30:0], fits};
  end

  // Start an operation or advance the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.op == AR_MUL) begin
          res_q  <= prod[31:0];
          done_q <= 1'b1;
        end else begin
          rem_q  <= '0;
          quo_q  <= a_i;
          den_q  <= b_i;
          cnt_q  <= 6'd32;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= quo_nx;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/ium_ring.sv */
// ----------------------------------------------------------------------------
// ium_ring
// Timestamp ring: one write port, one registered read port, per-entry valid
// bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module ium_ring import ium_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RingDepth)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0]          mem_q [RingDepth];
  logic [RingDepth-1:0] valid_q;
  logic [31:0]          rdata_q;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/idle_utilization_meter.sv */
// ----------------------------------------------------------------------------
// idle_utilization_meter
// Idle-count utilization meter: idle counter, sampling ring, interval latch,
// utilization query and delta histogram report over one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Idle ticks and sync marks: accepted back to back while the sequencer is idle.
// Query: multiply, divide and multiply on the shared unit into the result
//   register; goes straight to the output when the divisor is zero.
// Report: one delta per ring entry, each matched against up to D distinct bins
//   by a scan of the bin memory (D = RingDepth), then ReportSlots results.
// Reset: asynchronous, registers take their defaults, counters and ring read 0.

`include "idle_utilization_meter_assert.svh"

module idle_utilization_meter import ium_pkg::*; #(
  parameter int unsigned RingDepth   = RING_DEPTH_DEF,
  parameter int unsigned ReportSlots = REPORT_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // [31:0] timestamp
  input  logic [1:0]           s_axis_tuser,  // [1:0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata,  // [31:0] utilization, [63:32] tick_delta,
                                              // [68:64] delta_count, rest zero
  output logic                 m_axis_tuser,  // [0] result_kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(RingDepth);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = $clog2(RingDepth + 1);
  localparam int unsigned SW = (ReportSlots > 1) ? $clog2(ReportSlots) : 1;
  localparam int unsigned OW = $clog2(ReportSlots + 1);

  // Configuration registers
  logic [31:0] mult_first_q, mult_second_q, divisor_q, diag_mask_q;
  logic [15:0] marks_q;
  logic [30:0] full_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_first_q  <= 32'd10000;
      mult_second_q <= 32'd1;
      divisor_q     <= 32'd1000000;
      diag_mask_q   <= 32'hFFFF_FFFF;
      marks_q       <= 16'd1;
      full_scale_q  <= 31'd10000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MULT_FIRST:  mult_first_q  <= cfg_data_i;
        REG_MULT_SECOND: mult_second_q <= cfg_data_i;
        REG_DIVISOR:     divisor_q     <= cfg_data_i;
        REG_DIAG_MASK:   diag_mask_q   <= cfg_data_i;
        REG_MARKS:       marks_q       <= cfg_data_i[15:0];
        REG_FULL_SCALE:  full_scale_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  seq_state_e state_q, state_d;

  logic [31:0]   idle_cnt_q, cnt_last_q, latched_q;
  logic [15:0]   mark_cnt_q;
  logic [AW-1:0] widx_q;
  logic [31:0]   prod_q, util_q, prev_q, d_q;
  logic [AW-1:0] i_q;
  logic [NW-1:0] j_q, k_q, nb_q;
  logic [CW-1:0] extra_q;
  logic [SW-1:0] s_q;
  logic [31:0]   top_val_q [ReportSlots];
  logic [CW-1:0] top_cnt_q [ReportSlots];

  // Output register
  logic        m_valid_q, m_last_q;
  logic        m_user_q;
  logic [71:0] m_data_q;

  // Shared unit
  arith_req_t  ar_req;
  logic [31:0] ar_a, ar_b, ar_res;
  logic        ar_done;

  ium_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  // Ring
  logic          ring_we;
  logic [AW-1:0] ring_raddr;
  logic [31:0]   ring_rdata;

  ium_ring #(
    .RingDepth (RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ring_we),
    .waddr_i (widx_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Bin memory, one write port and one registered read port
  logic [31:0]   bin_val_mem [RingDepth];
  logic [CW-1:0] bin_cnt_mem [RingDepth];
  logic          bin_we;
  logic [AW-1:0] bin_waddr, bin_raddr;
  logic [31:0]   bin_wval, bin_rval;
  logic [CW-1:0] bin_wcnt, bin_rcnt;

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_val_mem[bin_waddr] <= bin_wval;
      bin_cnt_mem[bin_waddr] <= bin_wcnt;
    end
    bin_rval <= bin_val_mem[bin_raddr];
    bin_rcnt <= bin_cnt_mem[bin_raddr];
  end

  // Handshake helpers
  logic in_acc, out_free, emit;
  in_kind_e in_kind;
  logic sample_hit, last_delta, bin_match;
  logic [15:0] mark_nx;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_kind  = in_kind_e'(s_axis_tuser);
  assign out_free = !m_valid_q || m_axis_tready;
  assign sample_hit = ((idle_cnt_q & diag_mask_q) == diag_mask_q) &&
                      (idle_cnt_q > diag_mask_q);
  assign mark_nx    = mark_cnt_q + 16'd1;
  assign last_delta = (i_q == AW'(RingDepth - 1));
  assign bin_match  = (bin_rval == d_q);
  assign s_axis_tready = (state_q == ST_IDLE);

  // Insert a bin into the sorted top list
  logic [OW-1:0] ord;
  logic [31:0]   ins_val [ReportSlots];
  logic [CW-1:0] ins_cnt [ReportSlots];

  always_comb begin
    ord = '0;
    for (int n = 0; n < ReportSlots; n++) begin
      ord = ord + OW'(top_val_q[n] < bin_rval);
    end
    for (int n = 0; n < ReportSlots; n++) begin
      if (OW'(n) < ord) begin
        ins_val[n] = top_val_q[n];
        ins_cnt[n] = top_cnt_q[n];
      end else if (OW'(n) == ord) begin
        ins_val[n] = bin_rval;
        ins_cnt[n] = bin_rcnt;
      end else begin
        ins_val[n] = top_val_q[(n > 0) ? n - 1 : 0];
        ins_cnt[n] = top_cnt_q[(n > 0) ? n - 1 : 0];
      end
    end
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    ar_req     = '{start: 1'b0, op: AR_MUL};
    ar_a       = latched_q;
    ar_b       = mult_first_q;
    ring_we    = in_acc && (in_kind == KIND_IDLE_TICK) && sample_hit;
    ring_raddr = (state_q == ST_R_PREV) ? AW'(RingDepth - 1) : i_q;
    bin_raddr  = (state_q == ST_K_RD) ? k_q[AW-1:0] : j_q[AW-1:0];
    bin_we     = 1'b0;
    bin_waddr  = nb_q[AW-1:0];
    bin_wval   = d_q;
    bin_wcnt   = extra_q + CW'(1);
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_QUERY:  state_d = (divisor_q == '0) ? ST_Q_OUT : ST_Q_MUL1;
            KIND_REPORT: state_d = ST_R_PREV;
            default: ;
          endcase
        end
      end
      ST_Q_MUL1: begin
        ar_req  = '{start: 1'b1, op: AR_MUL};
        state_d = ST_Q_WAIT1;
      end
      ST_Q_WAIT1: if (ar_done) state_d = ST_Q_DIV;
      ST_Q_DIV: begin
        ar_req  = '{start: 1'b1, op: AR_DIV};
        ar_a    = prod_q;
        ar_b    = divisor_q;
        state_d = ST_Q_WAITD;
      end
      ST_Q_WAITD: if (ar_done) state_d = ST_Q_MUL2;
      ST_Q_MUL2: begin
        ar_req  = '{start: 1'b1, op: AR_MUL};
        ar_a    = prod_q;
        ar_b    = mult_second_q;
        state_d = ST_Q_WAIT2;
      end
      ST_Q_WAIT2: if (ar_done) state_d = ST_Q_OUT;
      ST_Q_OUT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_R_PREV:  state_d = ST_R_PREV2;
      ST_R_PREV2: state_d = ST_R_RD;
      ST_R_RD:    state_d = ST_R_DELTA;
      ST_R_DELTA: state_d = ST_B_RD;
      ST_B_RD: begin
        if (j_q == nb_q) begin
          bin_we  = (d_q != EMPTY_MARK);
          state_d = last_delta ? ST_K_RD : ST_R_RD;
        end else begin
          state_d = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        if (bin_match) begin
          bin_we    = 1'b1;
          bin_waddr = j_q[AW-1:0];
          bin_wcnt  = bin_rcnt + CW'(1);
          state_d   = last_delta ? ST_K_RD : ST_R_RD;
        end else begin
          state_d = ST_B_RD;
        end
      end
      ST_K_RD: begin
        if (k_q == nb_q) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = (s_q == SW'(ReportSlots - 1)) ? ST_IDLE : ST_K_RD;
          end
        end else begin
          state_d = ST_K_INS;
        end
      end
      ST_K_INS: state_d = ST_K_RD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters, meter state and report scratch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cnt_q <= '0;
      cnt_last_q <= '0;
      latched_q  <= '0;
      mark_cnt_q <= '0;
      widx_q     <= '0;
      prod_q     <= '0;
      util_q     <= '0;
      prev_q     <= '0;
      d_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      nb_q       <= '0;
      extra_q    <= '0;
      s_q        <= '0;
      for (int n = 0; n < ReportSlots; n++) begin
        top_val_q[n] <= EMPTY_MARK;
        top_cnt_q[n] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_kind)
              KIND_IDLE_TICK: begin
                idle_cnt_q <= idle_cnt_q + 32'd1;
                if (sample_hit) begin
                  widx_q <= (widx_q == AW'(RingDepth - 1)) ? '0 : widx_q + AW'(1);
                end
              end
              KIND_SYNC_MARK: begin
                if (mark_nx >= marks_q) begin
                  latched_q  <= idle_cnt_q - cnt_last_q;
                  cnt_last_q <= idle_cnt_q;
                  mark_cnt_q <= '0;
                end else begin
                  mark_cnt_q <= mark_nx;
                end
              end
              KIND_QUERY: util_q <= '0;
              default: begin
                i_q     <= '0;
                k_q     <= '0;
                nb_q    <= '0;
                extra_q <= '0;
                s_q     <= '0;
                for (int n = 0; n < ReportSlots; n++) begin
                  top_val_q[n] <= EMPTY_MARK;
                  top_cnt_q[n] <= '0;
                end
              end
            endcase
          end
        end
        ST_Q_WAIT1, ST_Q_WAITD: if (ar_done) prod_q <= ar_res;
        ST_Q_WAIT2: if (ar_done) util_q <= {1'b0, full_scale_q} - ar_res;
        ST_R_PREV2: prev_q <= ring_rdata;
        ST_R_DELTA: begin
          d_q    <= ring_rdata - prev_q;
          prev_q <= ring_rdata;
          j_q    <= '0;
        end
        ST_B_RD: begin
          if (j_q == nb_q) begin
            if (d_q == EMPTY_MARK) begin
              extra_q <= extra_q + CW'(1);
            end else begin
              extra_q <= '0;
              nb_q    <= nb_q + NW'(1);
            end
            if (!last_delta) i_q <= i_q + AW'(1);
          end
        end
        ST_B_CMP: begin
          if (bin_match) begin
            if (!last_delta) i_q <= i_q + AW'(1);
          end else begin
            j_q <= j_q + NW'(1);
          end
        end
        ST_K_RD: if (emit) s_q <= s_q + SW'(1);
        ST_K_INS: begin
          k_q <= k_q + NW'(1);
          for (int n = 0; n < ReportSlots; n++) begin
            top_val_q[n] <= ins_val[n];
            top_cnt_q[n] <= ins_cnt[n];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load a result, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_user_q  <= RES_UTIL;
      m_data_q  <= '0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
      if (state_q == ST_Q_OUT) begin
        m_user_q <= RES_UTIL;
        m_last_q <= 1'b1;
        m_data_q <= {40'd0, util_q};
      end else begin
        m_user_q <= RES_REPORT;
        m_last_q <= (s_q == SW'(ReportSlots - 1));
        m_data_q <= {3'd0, 5'(top_cnt_q[s_q]), top_val_q[s_q], 32'd0};
      end
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // Checks
  `IUM_ASSERT(a_nb_bound, clk_i, rst_ni, nb_q <= NW'(RingDepth))
  `IUM_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, (state_q == ST_B_RD) || (state_q == ST_B_CMP), j_q <= nb_q)
  `IUM_ASSERT_IMP(a_done_wait, clk_i, rst_ni, ar_done, (state_q == ST_Q_WAIT1) || (state_q == ST_Q_WAITD) || (state_q == ST_Q_WAIT2))

endmodule
